/* hw/rtl/rrs_pkg.sv */
// Shared constants, codes and types for the range add / range sum block.
`timescale 1ns / 1ps

package rrs_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int BLOCK_SIZE   = 32;
	localparam int NUM_BLOCKS   = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int OFS_W        = $clog2(BLOCK_SIZE);
	localparam int BLK_W        = $clog2(NUM_BLOCKS);
	localparam int CNT_W        = 11;
	localparam int DATA_W       = 64;
	localparam int VALUE_W      = 32;
	localparam int APB_W        = 32;
	localparam int ADDR_W       = 2;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_ELEMENTS);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ELEMENTS);

	localparam logic [ADDR_W-1:0] REG_ELEMENT_COUNT = 2'd0;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_ADD  = 2'd1;
	localparam logic [1:0] FUNC_SUM  = 2'd2;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t           op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} ram_req_t;

	typedef struct packed {
		logic [1:0]                func;
		logic [IDX_W-1:0]          first_index;
		logic [IDX_W-1:0]          last_index;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] range_sum;
		logic                     bad_range;
	} result_t;

endpackage

/* hw/rtl/rrs_alu.sv */
// Shared 64-bit add / subtract unit used by the arithmetic steps of the sequencer.
`timescale 1ns / 1ps

module rrs_alu (
	input  rrs_pkg::alu_req_t          req,
	output logic [rrs_pkg::DATA_W-1:0] y
);
	import rrs_pkg::*;

	always_comb begin
		unique case (req.op)
			ALU_ADD: y = req.a + req.b;
			ALU_SUB: y = req.a - req.b;
			default: y = req.a + req.b;
		endcase
	end

endmodule

/* hw/rtl/rrs_elem_ram.sv */
// Element store: single write port, single registered read port.
`timescale 1ns / 1ps

module rrs_elem_ram (
	input  logic                       clk,
	input  rrs_pkg::ram_req_t          req,
	output logic [rrs_pkg::DATA_W-1:0] rdata
);
	import rrs_pkg::*;

	logic [DATA_W-1:0] mem [MAX_ELEMENTS];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/rrs_apb_regs.sv */
// APB configuration register holding the element count.
`timescale 1ns / 1ps

module rrs_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rrs_pkg::ADDR_W-1:0] paddr,
	input  logic [rrs_pkg::APB_W-1:0]  pwdata,
	output logic [rrs_pkg::APB_W-1:0]  prdata,
	output logic                       pready,
	output logic [rrs_pkg::CNT_W-1:0]  element_count
);
	import rrs_pkg::*;

	logic [CNT_W-1:0] count_q;

	// The only register is read at address 0; writes do not decode the address, so every write lands on it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_RESET;
		end else if (psel && penable && pwrite) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_ELEMENT_COUNT) begin
			prdata = {{(APB_W-CNT_W){1'b0}}, count_q};
		end
	end

	assign pready        = 1'b1;
	assign element_count = count_q;

endmodule

/* hw/rtl/range_add_range_sum_blocks_core.sv */
// Top level: sequencer, block tables and result register of the range add / sum store.
`timescale 1ns / 1ps

// Sequence: a load goes through check, load steps A, B and C and done to the result beat; a
// bad range or unused code goes from check straight to done; a range add or sum takes element
// steps A and B per partial-block element and block step A (add) or steps A and B (sum) per
// whole block. One item is in flight at a time: busy stays high until the result beat. After
// reset a clearing pass zeroes the element store while busy is high; the block tables are
// cleared at once, the count register resets to the store depth. Results cannot be stalled.

module range_add_range_sum_blocks_core (
	input  logic                       clk,
	input  logic                       arst_n,
	// command channel
	input  logic                       start,
	output logic                       busy,
	input  rrs_pkg::item_t             item,
	// result channel: one beat per command, shown for a single cycle
	output logic                       done,
	output rrs_pkg::result_t           result,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rrs_pkg::ADDR_W-1:0] paddr,
	input  logic [rrs_pkg::APB_W-1:0]  pwdata,
	output logic [rrs_pkg::APB_W-1:0]  prdata,
	output logic                       pready
);
	import rrs_pkg::*;

	// Sequencer states.
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_EL_A  = 4'd3;
	localparam logic [3:0] S_EL_B  = 4'd4;
	localparam logic [3:0] S_BLK_A = 4'd5;
	localparam logic [3:0] S_BLK_B = 4'd6;
	localparam logic [3:0] S_LD_A  = 4'd7;
	localparam logic [3:0] S_LD_B  = 4'd8;
	localparam logic [3:0] S_LD_C  = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]        state_q, state_d;
	logic [IDX_W-1:0]  clr_q, clr_d;
	logic [IDX_W-1:0]  cur_q, cur_d;
	logic [DATA_W-1:0] acc_q, acc_d;
	logic              bad_q, bad_d;
	item_t             item_q, item_d;
	logic              done_q, done_d;
	result_t           result_q, result_d;

	// Per-block lazy add and stored-sum tables, each read at the current block only.
	logic [DATA_W-1:0] lazy_q [NUM_BLOCKS];
	logic [DATA_W-1:0] base_q [NUM_BLOCKS];
	logic              lazy_we, base_we;

	logic [CNT_W-1:0]  element_count;
	logic [CNT_W-1:0]  live_count;
	logic [DATA_W-1:0] delta;
	logic [BLK_W-1:0]  blk;
	logic [DATA_W-1:0] lazy_rd, base_rd;
	logic [DATA_W-1:0] rdata;
	logic [DATA_W-1:0] alu_y;
	alu_req_t          alu_req;
	ram_req_t          ram_req;
	logic              go;
	logic [IDX_W-1:0]  go_pos;
	logic              range_bad;
	logic              load_bad;

	rrs_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.element_count (element_count)
	);

	rrs_elem_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	rrs_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	// The count register may exceed the store; clamp it to the store depth.
	assign live_count = (element_count > CNT_MAX) ? CNT_MAX : element_count;
	assign load_bad   = {1'b0, item_q.first_index} >= live_count;
	assign range_bad  = (item_q.first_index > item_q.last_index) ||
	                    ({1'b0, item_q.last_index} >= live_count);

	assign delta   = {{(DATA_W-VALUE_W){item_q.value[VALUE_W-1]}}, item_q.value};
	assign blk     = cur_q[IDX_W-1:OFS_W];
	assign lazy_rd = lazy_q[blk];
	assign base_rd = base_q[blk];

	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		cur_d    = cur_q;
		acc_d    = acc_q;
		bad_d    = bad_q;
		item_d   = item_q;
		done_d   = 1'b0;
		result_d = result_q;
		lazy_we  = 1'b0;
		base_we  = 1'b0;
		go       = 1'b0;
		go_pos   = cur_q;
		alu_req.op = ALU_ADD;
		alu_req.a  = acc_q;
		alu_req.b  = rdata;
		ram_req.we    = 1'b0;
		ram_req.waddr = cur_q;
		ram_req.wdata = alu_y;
		ram_req.re    = 1'b0;
		ram_req.raddr = cur_q;

		unique case (state_q)
			S_CLEAR: begin
				// One entry of the element store is zeroed each cycle.
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_q;
				ram_req.wdata = '0;
				clr_d         = clr_q + 1'b1;
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					item_d  = item;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				acc_d = '0;
				cur_d = item_q.first_index;
				unique case (item_q.func)
					FUNC_LOAD: begin
						bad_d = load_bad;
						if (load_bad) begin
							state_d = S_DONE;
						end else begin
							ram_req.re    = 1'b1;
							ram_req.raddr = item_q.first_index;
							state_d       = S_LD_A;
						end
					end
					FUNC_ADD, FUNC_SUM: begin
						bad_d = range_bad;
						if (range_bad) begin
							state_d = S_DONE;
						end else begin
							go     = 1'b1;
							go_pos = item_q.first_index;
						end
					end
					default: begin
						// The unused code does nothing and reports a good range.
						bad_d   = 1'b0;
						state_d = S_DONE;
					end
				endcase
			end
			S_EL_A: begin
				// First half of an element: the stored value itself.
				if (item_q.func == FUNC_ADD) begin
					alu_req.a  = rdata;
					alu_req.b  = delta;
					ram_req.we = 1'b1;
				end else begin
					alu_req.a = acc_q;
					alu_req.b = rdata;
					acc_d     = alu_y;
				end
				state_d = S_EL_B;
			end
			S_EL_B: begin
				// Second half: the block sum for an add, the lazy value for a sum.
				if (item_q.func == FUNC_ADD) begin
					alu_req.a = base_rd;
					alu_req.b = delta;
					base_we   = 1'b1;
				end else begin
					alu_req.a = acc_q;
					alu_req.b = lazy_rd;
					acc_d     = alu_y;
				end
				if (cur_q == item_q.last_index) begin
					state_d = S_DONE;
				end else begin
					go     = 1'b1;
					go_pos = cur_q + 1'b1;
				end
			end
			S_BLK_A: begin
				if (item_q.func == FUNC_ADD) begin
					alu_req.a = lazy_rd;
					alu_req.b = delta;
					lazy_we   = 1'b1;
					go        = 1'b1;
					go_pos    = cur_q + IDX_W'(BLOCK_SIZE);
				end else begin
					alu_req.a = acc_q;
					alu_req.b = base_rd;
					acc_d     = alu_y;
					state_d   = S_BLK_B;
				end
			end
			S_BLK_B: begin
				// A whole block holds every element, so its lazy value counts BLOCK_SIZE times.
				alu_req.a = acc_q;
				alu_req.b = lazy_rd << OFS_W;
				acc_d     = alu_y;
				go        = 1'b1;
				go_pos    = cur_q + IDX_W'(BLOCK_SIZE);
			end
			S_LD_A: begin
				// The stored value that gives the wanted true value.
				alu_req.op = ALU_SUB;
				alu_req.a  = delta;
				alu_req.b  = lazy_rd;
				acc_d      = alu_y;
				state_d    = S_LD_B;
			end
			S_LD_B: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = acc_q;
				alu_req.op    = ALU_SUB;
				alu_req.a     = acc_q;
				alu_req.b     = rdata;
				acc_d         = alu_y;
				state_d       = S_LD_C;
			end
			S_LD_C: begin
				alu_req.a = base_rd;
				alu_req.b = acc_q;
				base_we   = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				done_d             = 1'b1;
				result_d.bad_range = bad_q;
				result_d.range_sum = (item_q.func == FUNC_SUM && !bad_q) ? acc_q : '0;
				state_d            = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Moving to a new position: a block-aligned position whose block lies wholly
		// below the last block is taken as a whole block, otherwise its element is fetched.
		if (go) begin
			cur_d = go_pos;
			if (go_pos[OFS_W-1:0] == '0 &&
			    go_pos[IDX_W-1:OFS_W] < item_q.last_index[IDX_W-1:OFS_W]) begin
				state_d = S_BLK_A;
			end else begin
				state_d       = S_EL_A;
				ram_req.re    = 1'b1;
				ram_req.raddr = go_pos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		acc_q    <= acc_d;
		bad_q    <= bad_d;
		item_q   <= item_d;
		result_q <= result_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_BLOCKS; k++) begin
				lazy_q[k] <= '0;
				base_q[k] <= '0;
			end
		end else begin
			if (lazy_we) begin
				lazy_q[blk] <= alu_y;
			end
			if (base_we) begin
				base_q[blk] <= alu_y;
			end
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
